// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is low.
`define SLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sla_pkg.sv =====
// ---------------------------------------------------------------------------
// List package
// Opcodes, status codes and the command broadcast to the cell chain.
// ---------------------------------------------------------------------------
package sla_pkg;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_APPEND    = 3'd1;
  localparam logic [2:0] OP_INS_AFTER = 3'd2;
  localparam logic [2:0] OP_DELETE    = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/sla_cell.sv =====
// ---------------------------------------------------------------------------
// List cell
// Holds one entry; loads the new word, takes its lower or upper neighbor.
// ---------------------------------------------------------------------------
module sla_cell
  import sla_pkg::*;
#(
  parameter int IDX_W = 7,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [31:0]      left_data,
  input  logic signed [31:0]      right_data,
  output logic signed [31:0]      data
);

  localparam logic [IDX_W-1:0] INDEX_C = IDX_W'(INDEX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_INSERT: begin
        if (idx == INDEX_C) begin
          data_nxt = cmd.value;
        end else if (idx < INDEX_C) begin
          data_nxt = left_data;
        end
      end
      CELL_DELETE: begin
        if (idx <= INDEX_C) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== hw/rtl/shifting_array_list.sv =====
// ---------------------------------------------------------------------------
// Shifting array list
// Bounded ordered list of signed words held in a chain of cells.
// ---------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     start & !busy        in_opcode, in_value, in_position
// result    out_valid (strobe)   out_status, out_count, out_read_value
//
// The result appears on the cycle after the transfer, and a new command is
// taken in every cycle. This rate is set by the cell chain, where every cell
// moves its entry at the same clock edge.
// Reset clears the length and the result strobe; entries stay undefined.
// The receiver cannot stall, so busy stays low.
// ---------------------------------------------------------------------------
module shifting_array_list
  import sla_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_position,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [7:0]         out_count,
  output logic signed [31:0] out_read_value
);

`include "assert_macros.svh"

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  logic [LEN_W-1:0]   length_r;
  logic [LEN_W-1:0]   length_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [1:0]         out_status_nxt;
  logic [7:0]         out_count_r;
  logic signed [31:0] out_read_value_r;
  logic signed [31:0] out_read_value_nxt;

  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   cmd_idx;
  logic signed [31:0] cell_data [CAPACITY];

  logic               full;
  logic               pos_bad;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   pos_inc;

  assign full    = (length_r == CAP_LEN);
  assign pos_ext = CMP_W'(in_position);
  assign pos_inc = pos_ext + CMP_W'(1);
  assign pos_bad = (pos_ext >= CMP_W'(length_r));

  always_comb begin
    cmd.op             = CELL_HOLD;
    cmd.value          = in_value;
    cmd_idx            = '0;
    length_nxt         = length_r;
    out_status_nxt     = ST_DONE;
    out_read_value_nxt = '0;
    if (start) begin
      unique case (in_opcode)
        OP_INS_FRONT: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op     = CELL_INSERT;
            length_nxt = length_r + LEN_W'(1);
          end
        end
        OP_APPEND: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op     = CELL_INSERT;
            cmd_idx    = IDX_W'(length_r);
            length_nxt = length_r + LEN_W'(1);
          end
        end
        OP_INS_AFTER: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else if (pos_bad) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            cmd.op     = CELL_INSERT;
            cmd_idx    = IDX_W'(pos_inc);
            length_nxt = length_r + LEN_W'(1);
          end
        end
        OP_DELETE: begin
          if (pos_bad) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            cmd.op     = CELL_DELETE;
            cmd_idx    = IDX_W'(pos_ext);
            length_nxt = length_r - LEN_W'(1);
          end
        end
        OP_READ: begin
          if (pos_bad) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            out_read_value_nxt = cell_data[IDX_W'(pos_ext)];
          end
        end
        default: begin
          out_status_nxt = ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = in_value;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    sla_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (cmd_idx),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      length_r    <= length_nxt;
      out_valid_r <= start;
    end
    out_status_r     <= out_status_nxt;
    out_count_r      <= 8'(length_nxt);
    out_read_value_r <= out_read_value_nxt;
  end

  assign busy           = 1'b0;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_read_value = out_read_value_r;

  `SLA_ASSERT_NEXT(a_result_follows, clk, rst_n, start, out_valid_r, "missing result strobe")
  `SLA_ASSERT_NEXT(a_no_spurious, clk, rst_n, !start, !out_valid_r, "result without transfer")
  `SLA_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, length_r <= CAP_LEN, "length above capacity")
  `SLA_ASSERT_IMP(a_full_status, clk, rst_n, out_valid_r && (out_status_r == ST_FULL), length_r == CAP_LEN, "full status while not full")
  `SLA_ASSERT_NEXT(a_len_step, clk, rst_n, 1'b1, (length_r == $past(length_r)) || (length_r == $past(length_r) + LEN_W'(1)) || (length_r + LEN_W'(1) == $past(length_r)), "length moved by more than one")

endmodule

// ===== dv/tb_shifting_array_list.sv =====
// ---------------------------------------------------------------------------
// Shifting array list testbench
// Drives list commands through the start/busy port, with a directed table
// first and then long fill and drain swings with random content. Every
// result strobe is checked field by field against the table's fields where
// known, else a behavioral copy of the list, in an ordered pending queue.
// ---------------------------------------------------------------------------
module tb_shifting_array_list
  import sla_pkg::*;
();

  localparam int CAPACITY       = 128;
  localparam int IDX_W          = $clog2(CAPACITY);
  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  count;
    logic [31:0] rdata;
  } list_result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] val;
    logic [6:0]  pos;
    logic        known;
    logic [1:0]  st;
    logic [7:0]  cnt;
    logic [31:0] rd;
  } list_step_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_opcode = '0;
  logic signed [31:0] in_value = '0;
  logic [6:0]         in_position = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [7:0]         out_count;
  logic signed [31:0] out_read_value;

  logic [31:0]  shadow_words [CAPACITY];
  int           shadow_len = 0;
  list_result_t pending_results [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           filling = 1'b1;

  list_step_t directed_plan [0:24] = '{
    '{OP_READ,      32'h0000_0000, 7'd0,   1'b1, ST_BADPOS, 8'd0, 32'h0},
    '{OP_DELETE,    32'h0000_0000, 7'd0,   1'b1, ST_BADPOS, 8'd0, 32'h0},
    '{OP_INS_AFTER, 32'h0000_0005, 7'd0,   1'b1, ST_BADPOS, 8'd0, 32'h0},
    '{OP_APPEND,    32'h7FFF_FFFF, 7'd0,   1'b1, ST_DONE,   8'd1, 32'h0},
    '{OP_INS_FRONT, 32'h8000_0000, 7'd0,   1'b1, ST_DONE,   8'd2, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd0,   1'b1, ST_DONE,   8'd2, 32'h8000_0000},
    '{OP_READ,      32'h0000_0000, 7'd1,   1'b1, ST_DONE,   8'd2, 32'h7FFF_FFFF},
    '{OP_INS_AFTER, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_DONE,   8'd3, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd1,   1'b1, ST_DONE,   8'd3, 32'hFFFF_FFFF},
    '{OP_INS_AFTER, 32'h5A5A_5A5A, 7'd2,   1'b1, ST_DONE,   8'd4, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd3,   1'b1, ST_DONE,   8'd4, 32'h5A5A_5A5A},
    '{OP_READ,      32'h0000_0000, 7'd4,   1'b1, ST_BADPOS, 8'd4, 32'h0},
    '{OP_DELETE,    32'h0000_0000, 7'd3,   1'b1, ST_DONE,   8'd3, 32'h0},
    '{OP_DELETE,    32'h0000_0000, 7'd0,   1'b1, ST_DONE,   8'd2, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd0,   1'b0, ST_DONE,   8'd0, 32'h0},
    '{OP_SPARE_FIRST, 32'hFFFF_FFFF, 7'd127, 1'b1, ST_DONE, 8'd2, 32'h0},
    '{OP_SPARE_MID,   32'h1234_5678, 7'd1,   1'b1, ST_DONE, 8'd2, 32'h0},
    '{OP_SPARE_LAST,  32'h0000_0000, 7'd0,   1'b1, ST_DONE, 8'd2, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd127, 1'b1, ST_BADPOS, 8'd2, 32'h0},
    '{OP_INS_AFTER, 32'h0BAD_F00D, 7'd127, 1'b1, ST_BADPOS, 8'd2, 32'h0},
    '{OP_DELETE,    32'h0000_0000, 7'd127, 1'b1, ST_BADPOS, 8'd2, 32'h0},
    '{OP_INS_FRONT, 32'h0000_0001, 7'd0,   1'b0, ST_DONE,   8'd0, 32'h0},
    '{OP_APPEND,    32'hFFFF_FFFE, 7'd0,   1'b0, ST_DONE,   8'd0, 32'h0},
    '{OP_READ,      32'h0000_0000, 7'd1,   1'b0, ST_DONE,   8'd0, 32'h0},
    '{OP_DELETE,    32'h0000_0000, 7'd1,   1'b0, ST_DONE,   8'd0, 32'h0}
  };

  shifting_array_list #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_read_value(out_read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [31:0] val,
                                                 input logic [6:0] pos);
    list_result_t r;
    int i;
    bit full;
    r.status = ST_DONE;
    r.rdata = '0;
    full = (shadow_len >= CAPACITY);
    case (op)
      OP_INS_FRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > 0; i--) begin
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i-1)];
          end
          shadow_words[0] = val;
          shadow_len++;
        end
      end
      OP_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[IDX_W'(shadow_len)] = val;
          shadow_len++;
        end
      end
      OP_INS_AFTER: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (int'(pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_len; i > int'(pos) + 1; i--) begin
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i-1)];
          end
          shadow_words[IDX_W'(int'(pos) + 1)] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (int'(pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(pos); i + 1 < shadow_len; i++) begin
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i+1)];
          end
          shadow_len--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= shadow_len) r.status = ST_BADPOS;
        else r.rdata = shadow_words[pos];
      end
      default: begin
      end
    endcase
    r.count = shadow_len[7:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [31:0] val, input logic [6:0] pos,
                          input bit known, input list_result_t typed);
    list_result_t predicted;
    start       <= 1'b1;
    in_opcode   <= op;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_list_op(op, val, pos);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 28) return OP_APPEND;
      if (r < 50) return OP_INS_FRONT;
      if (r < 72) return OP_INS_AFTER;
      if (r < 86) return OP_DELETE;
      return OP_READ;
    end
    if (r < 8) return OP_APPEND;
    if (r < 14) return OP_INS_FRONT;
    if (r < 20) return OP_INS_AFTER;
    if (r < 75) return OP_DELETE;
    return OP_READ;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", {30'b0, out_status}, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) report("status", {30'b0, out_status}, {30'b0, want.status});
          if (out_count !== want.count) report("count", {24'b0, out_count}, {24'b0, want.count});
          if (out_read_value !== want.rdata) report("read_value", out_read_value, want.rdata);
        end
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] pos;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[k]) begin
      pace();
      send_cmd(directed_plan[k].op, directed_plan[k].val, directed_plan[k].pos,
               directed_plan[k].known,
               '{directed_plan[k].st, directed_plan[k].cnt, directed_plan[k].rd});
    end
    drain();

    // Each swing fills the list to capacity and empties it again, lingering at
    // both ends so that refused inserts and refused deletes both occur.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 200) drain();
      pace();
      if (shadow_len == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (shadow_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if (shadow_len > 0 && $urandom_range(0, 9) != 0) pos = 7'($urandom_range(0, shadow_len - 1));
      else pos = 7'($urandom_range(0, 127));
      send_cmd(pick_op(), $urandom, pos, 1'b0, '0);
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sla_pkg.sv
hw/rtl/sla_cell.sv
hw/rtl/shifting_array_list.sv
dv/tb_shifting_array_list.sv
